/* rtl/qphd_pkg.sv */
// ----------------------------------------------------------------------------
// qphd_pkg: shared definitions for the quadratic probe hash dictionary
// Request modes, result status codes, table entry layout and default sizes.
// ----------------------------------------------------------------------------
package qphd_pkg;

	localparam int QPHD_TABLE_SIZE = 16;
	localparam int QPHD_KEY_BYTES  = 8;

	localparam int KEY_W    = 64;
	localparam int VAL_W    = 64;
	localparam int ENTRY_W  = 1 + KEY_W + VAL_W;
	localparam int MODE_W   = 2;
	localparam int STATUS_W = 3;
	localparam int SLOT_W   = 4;

	// Byte sum of a key of up to eight bytes stays below 2048.
	localparam int SUM_W = 11;

	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
	localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd4;

endpackage

/* rtl/qphd_ram.sv */
// ----------------------------------------------------------------------------
// qphd_ram: generic single-clock RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module qphd_ram
	import qphd_pkg::*;
#(
	parameter int WIDTH = ENTRY_W,
	parameter int DEPTH = QPHD_TABLE_SIZE,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/quadratic_probe_hash_dictionary_core.sv */
// ----------------------------------------------------------------------------
// quadratic_probe_hash_dictionary_core: open-addressing key-value dictionary
// Insert, search and delete with quadratic probing over one table RAM.
// ----------------------------------------------------------------------------
// Usage.
// A request (mode, key, value) transfers at a rising edge where start is high
// and busy is low. Mode 0 inserts, 1 searches, 2 deletes; mode 3 is answered
// as not found. Exactly one result (status, slot, found_value) follows, shown
// for a single cycle with done high. The receiver cannot stall, so the block
// never waits on it: busy drops in the same cycle that done is shown, and the
// next request may transfer at the end of that cycle.
//
// Steps: the transfer edge captures the request and normalizes the key, the
// hash state forms the quotient of the byte sum by a reciprocal multiply, the
// home state takes the remainder as the home slot, then the probe state issues
// one RAM read per probe, each checked when its registered read data returns.
// A mode 3 request is answered from the idle state. The single RAM read port
// allows one probe per cycle.
//
// Reset clears the control state and then runs a clearing pass that writes
// every entry invalid; busy stays high during that pass.
// ----------------------------------------------------------------------------
module quadratic_probe_hash_dictionary_core
	import qphd_pkg::*;
#(
	parameter int TABLE_SIZE = QPHD_TABLE_SIZE,
	parameter int KEY_BYTES  = QPHD_KEY_BYTES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [MODE_W-1:0]   mode,
	input  logic [KEY_W-1:0]    key,
	input  logic [VAL_W-1:0]    value,
	output logic                done,
	output logic [STATUS_W-1:0] status,
	output logic [SLOT_W-1:0]   slot,
	output logic [VAL_W-1:0]    found_value
);

	localparam int AW    = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
	localparam int AW1   = AW + 1;
	localparam int CNT_W = $clog2(TABLE_SIZE + 1);

	// Reciprocal of TABLE_SIZE, exact for every byte sum below 2**SUM_W.
	localparam int REC_SH = SUM_W + AW;
	localparam int REC_W  = SUM_W + 1;
	localparam int PROD_W = SUM_W + REC_W;
	localparam int QT_W   = 2 * SUM_W;

	localparam logic [AW1-1:0]   T_EXT    = AW1'(TABLE_SIZE);
	localparam logic [SUM_W-1:0] T_SUM    = SUM_W'(TABLE_SIZE);
	localparam logic [REC_W-1:0] REC_M    = REC_W'((2 ** REC_SH + TABLE_SIZE - 1) / TABLE_SIZE);
	localparam logic [AW-1:0]    LAST_A   = AW'(TABLE_SIZE - 1);
	localparam logic [CNT_W-1:0] CNT_ALL  = CNT_W'(TABLE_SIZE);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TABLE_SIZE - 1);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_HOME,
		S_PROBE
	} state_t;

	state_t state_q;

	// Request registers.
	logic [MODE_W-1:0] mode_q;
	logic [KEY_W-1:0]  key_q;
	logic [VAL_W-1:0]  val_q;
	logic [SUM_W-1:0]  sum_q;
	logic [SUM_W-1:0]  quo_q;

	// Probe sequencer: position, step to the next square, and counters.
	logic [AW-1:0]    clr_q;
	logic [AW-1:0]    p_q;
	logic [AW-1:0]    d_q;
	logic [CNT_W-1:0] iss_q;
	logic [CNT_W-1:0] chk_q;

	// Read in flight: the slot whose entry arrives from the RAM next cycle.
	logic             chk_s1;
	logic [AW-1:0]    addr_s1;

	// Result registers.
	logic                done_q;
	logic [STATUS_W-1:0] status_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [VAL_W-1:0]    fv_q;

	// Key normalization: low KEY_BYTES bytes up to the first zero byte.
	logic [KEY_W-1:0] nkey;
	logic [SUM_W-1:0] nsum;

	always_comb begin
		logic alive;
		logic [7:0] kb;
		alive = 1'b1;
		nkey  = '0;
		nsum  = '0;
		for (int b = 0; b < 8; b++) begin
			kb = key[8*b +: 8];
			alive = alive && (b < KEY_BYTES) && (kb != 8'd0);
			if (alive) begin
				nkey[8*b +: 8] = kb;
				nsum = nsum + SUM_W'(kb);
			end
		end
	end

	// Home slot: the quotient comes from a multiply by the reciprocal, and
	// the remainder is the sum less quotient times size on the next cycle.
	logic [PROD_W-1:0] quo_prod;
	logic [QT_W-1:0]   qt_prod;
	logic [AW-1:0]     home;

	always_comb begin
		quo_prod = PROD_W'(sum_q) * PROD_W'(REC_M);
		qt_prod  = QT_W'(quo_q) * QT_W'(T_SUM);
		home     = AW'(sum_q - qt_prod[SUM_W-1:0]);
	end

	// Next probe position: (home + i*i) mod size advances by (2i+1) mod size.
	logic [AW1-1:0] p_sum;
	logic [AW1-1:0] d_sum;
	logic [AW-1:0]  p_next;
	logic [AW-1:0]  d_next;

	always_comb begin
		p_sum  = {1'b0, p_q} + {1'b0, d_q};
		d_sum  = {1'b0, d_q} + AW1'(2);
		p_next = AW'((p_sum >= T_EXT) ? p_sum - T_EXT : p_sum);
		d_next = AW'((d_sum >= T_EXT) ? d_sum - T_EXT : d_sum);
	end

	// Table RAM: each entry holds valid, key and value.
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic               ram_re;
	logic [ENTRY_W-1:0] ram_rdata;

	logic             rd_valid;
	logic [KEY_W-1:0] rd_key;
	logic [VAL_W-1:0] rd_val;
	logic             hit;

	assign rd_valid = ram_rdata[ENTRY_W-1];
	assign rd_key   = ram_rdata[KEY_W+VAL_W-1:VAL_W];
	assign rd_val   = ram_rdata[VAL_W-1:0];

	// Insert wants a free slot; search and delete want a live matching key.
	assign hit = (mode_q == MODE_INSERT) ? !rd_valid : (rd_valid && (rd_key == key_q));

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_s1;
		ram_wdata = {1'b1, key_q, val_q};
		ram_re    = 1'b0;
		case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			S_PROBE: begin
				// Reads run one slot ahead of the check; a hit discards the spare read.
				ram_re = (iss_q != CNT_ALL);
				if (chk_s1 && hit) begin
					if (mode_q == MODE_INSERT) begin
						ram_we = 1'b1;
					end else if (mode_q == MODE_DELETE) begin
						// Write back the entry with its valid mark cleared.
						ram_we    = 1'b1;
						ram_wdata = {1'b0, rd_key, rd_val};
					end
				end
			end
			default: begin
			end
		endcase
	end

	qphd_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_SIZE)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(p_q),
		.rdata(ram_rdata)
	);

	// Control state and registered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
			chk_s1  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST_A) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						mode_q <= mode;
						key_q  <= nkey;
						val_q  <= value;
						sum_q  <= nsum;
						if (mode == MODE_UNUSED) begin
							// Nothing to look up: answer at once.
							done_q   <= 1'b1;
							status_q <= ST_NOT_FOUND;
							slot_q   <= '0;
							fv_q     <= '0;
						end else begin
							state_q <= S_HASH;
						end
					end
				end
				S_HASH: begin
					quo_q   <= SUM_W'(quo_prod >> REC_SH);
					state_q <= S_HOME;
				end
				S_HOME: begin
					state_q <= S_PROBE;
					p_q     <= home;
					d_q     <= AW'(1);
					iss_q   <= '0;
					chk_q   <= '0;
					chk_s1  <= 1'b0;
				end
				S_PROBE: begin
					chk_s1 <= ram_re;
					if (ram_re) begin
						addr_s1 <= p_q;
						p_q     <= p_next;
						d_q     <= d_next;
						iss_q   <= iss_q + CNT_W'(1);
					end
					if (chk_s1) begin
						chk_q <= chk_q + CNT_W'(1);
						if (hit) begin
							state_q <= S_IDLE;
							chk_s1  <= 1'b0;
							done_q  <= 1'b1;
							slot_q  <= SLOT_W'(addr_s1);
							case (mode_q)
								MODE_INSERT: begin
									status_q <= ST_INSERTED;
									fv_q     <= '0;
								end
								MODE_DELETE: begin
									status_q <= ST_DELETED;
									fv_q     <= rd_val;
								end
								default: begin
									status_q <= ST_FOUND;
									fv_q     <= rd_val;
								end
							endcase
						end else if (chk_q == CNT_LAST) begin
							// Every slot on the sequence was tried.
							state_q  <= S_IDLE;
							chk_s1   <= 1'b0;
							done_q   <= 1'b1;
							status_q <= (mode_q == MODE_INSERT) ? ST_FULL : ST_NOT_FOUND;
							slot_q   <= '0;
							fv_q     <= '0;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign status      = status_q;
	assign slot        = slot_q;
	assign found_value = fv_q;

endmodule
